FILE: rtl/ubxfb_pkg.sv
// Shared constants, phase codes and types of the serial frame builder.
package ubxfb_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output sequencer phases, in emission order.
  localparam int PH_W = 4;
  localparam logic [PH_W-1:0] PH_SYNC1 = 4'd0;
  localparam logic [PH_W-1:0] PH_SYNC2 = 4'd1;
  localparam logic [PH_W-1:0] PH_CLASS = 4'd2;
  localparam logic [PH_W-1:0] PH_IDENT = 4'd3;
  localparam logic [PH_W-1:0] PH_LENLO = 4'd4;
  localparam logic [PH_W-1:0] PH_LENHI = 4'd5;
  localparam logic [PH_W-1:0] PH_DATA  = 4'd6;
  localparam logic [PH_W-1:0] PH_CKA   = 4'd7;
  localparam logic [PH_W-1:0] PH_CKB   = 4'd8;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic        hdr;       // first item of a frame: emit sync and header
    logic        has_data;  // emit the payload byte
    logic        last;      // payload used up: emit the checksum pair
    logic [7:0]  msg_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/ubxfb_channels.sv
// Valid/ready channel interfaces for the input items and the framed bytes.
interface ubxfb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_class;
  logic [7:0]  msg_ident;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, msg_class, msg_ident, payload_length, data_byte,
                  input ready);
  modport sink (input valid, msg_class, msg_ident, payload_length, data_byte,
                output ready);
endinterface

interface ubxfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, out_byte, run_end, frame_end, input ready);
  modport sink (input valid, out_byte, run_end, frame_end, output ready);
endinterface

FILE: rtl/ubx_frame_builder_top.sv
// Top level of the serial frame builder with 8-bit Fletcher checksum.
//
// Input channel in_ch carries one payload byte per item; on the first item
// of a frame msg_class, msg_ident and payload_length are taken as well.
// Output channel out_ch carries one framed byte per item: two sync bytes,
// class, id, length low and high, the payload, then checksum A and B.
// run_end marks the last byte caused by an input item, frame_end the
// second checksum byte. A zero length gives a frame with an empty payload.
// An accepted item goes into a queue entry and from there into the output
// register. The output runs at one byte per cycle while the queue holds
// items and the receiver takes them: a mid-frame item gives one byte, the
// first of a frame seven (nine if also last), the last item three (eight
// for an empty frame), all via the single output register that the back-end
// sequencer fills. A four-entry queue lets input items enter while header or
// checksum bytes are still going out. When the receiver stalls, the output
// byte holds, the queue fills and then in_ch.ready drops. Reset clears the
// frame position, queue and output valid flag; no clearing pass is needed.
module ubx_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  ubxfb_in_if.sink    in_ch,
  ubxfb_out_if.source out_ch
);

  ubxfb_pkg::cmd_t    push_cmd, head_cmd;
  ubxfb_pkg::q_stat_t q_stat;
  logic               push, pop;

  ubxfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ubxfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  ubxfb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_cmd (head_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

FILE: rtl/ubxfb_front.sv
// Front end: accepts items, tracks frame position and classifies each item.
module ubxfb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ubxfb_in_if.sink             in_ch,
  input  ubxfb_pkg::q_stat_t   q_stat,
  output logic                 push,
  output ubxfb_pkg::cmd_t      push_cmd
);

  logic        in_frame_r, in_frame_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len_now;
  logic        has_data;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    len_now  = in_frame_r ? left_r : in_ch.payload_length;
    has_data = (len_now != 16'd0);
    left_nxt = len_now - {15'd0, has_data};
    in_frame_nxt = (left_nxt != 16'd0);

    push_cmd.hdr            = !in_frame_r;
    push_cmd.has_data       = has_data;
    push_cmd.last           = (left_nxt == 16'd0);
    push_cmd.msg_class      = in_ch.msg_class;
    push_cmd.msg_ident      = in_ch.msg_ident;
    push_cmd.payload_length = in_ch.payload_length;
    push_cmd.data_byte      = in_ch.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      left_r     <= 16'd0;
    end else if (push) begin
      in_frame_r <= in_frame_nxt;
      left_r     <= left_nxt;
    end
  end

  // While inside a frame there is always at least one payload byte to come.
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (left_r != 16'd0))
    else $error("in frame with no payload left");
  a_mid_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_frame_r) |-> push_cmd.has_data)
    else $error("mid-frame item classified without payload byte");
  a_hdr_or_last_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !push_cmd.has_data) |-> (push_cmd.hdr && push_cmd.last))
    else $error("item without payload byte is not an empty frame");

endmodule

FILE: rtl/ubxfb_queue.sv
// Small FIFO of classified items between front and back.
module ubxfb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ubxfb_pkg::cmd_t      push_cmd,
  input  logic                 pop,
  output ubxfb_pkg::cmd_t      head_cmd,
  output ubxfb_pkg::q_stat_t   q_stat
);

  localparam int D = ubxfb_pkg::QUEUE_DEPTH;

  ubxfb_pkg::cmd_t                 mem_r [D];
  logic [ubxfb_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ubxfb_pkg::QCNT_W-1:0]    count_r;
  logic                            do_push, do_pop;

  assign q_stat.full  = (count_r == ubxfb_pkg::QCNT_W'(D));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  function automatic logic [ubxfb_pkg::QPTR_W-1:0] ptr_inc(
    input logic [ubxfb_pkg::QPTR_W-1:0] p);
    ptr_inc = (p == ubxfb_pkg::QPTR_W'(D - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ubxfb_pkg::QCNT_W'(D))
    else $error("queue count beyond depth");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into a full queue");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/ubxfb_back.sv
// Back end: sequences header, payload and checksum bytes into the output register.
module ubxfb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ubxfb_pkg::cmd_t      head_cmd,
  input  ubxfb_pkg::q_stat_t   q_stat,
  output logic                 pop,
  ubxfb_out_if.source          out_ch
);

  logic [ubxfb_pkg::PH_W-1:0] phase_r, phase_nxt, cur_ph;
  logic                       started_r, started_nxt;
  logic [7:0]                 sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic                       run_end_r, run_end_nxt;
  logic                       frame_end_r, frame_end_nxt;
  logic                       fire, done, summed;
  logic [7:0]                 cur_byte, sum_a_add;
  logic [ubxfb_pkg::PH_W-1:0] next_ph;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_end   = run_end_r;
  assign out_ch.frame_end = frame_end_r;

  assign fire = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign pop  = fire && done;

  always_comb begin
    if (started_r) begin
      cur_ph = phase_r;
    end else if (head_cmd.hdr) begin
      cur_ph = ubxfb_pkg::PH_SYNC1;
    end else if (head_cmd.has_data) begin
      cur_ph = ubxfb_pkg::PH_DATA;
    end else begin
      cur_ph = ubxfb_pkg::PH_CKA;
    end

    done    = 1'b0;
    summed  = 1'b0;
    next_ph = cur_ph + 1'b1;
    case (cur_ph)
      ubxfb_pkg::PH_SYNC1: cur_byte = ubxfb_pkg::SYNC_FIRST;
      ubxfb_pkg::PH_SYNC2: cur_byte = ubxfb_pkg::SYNC_SECOND;
      ubxfb_pkg::PH_CLASS: begin
        cur_byte = head_cmd.msg_class;
        summed   = 1'b1;
      end
      ubxfb_pkg::PH_IDENT: begin
        cur_byte = head_cmd.msg_ident;
        summed   = 1'b1;
      end
      ubxfb_pkg::PH_LENLO: begin
        cur_byte = head_cmd.payload_length[7:0];
        summed   = 1'b1;
      end
      ubxfb_pkg::PH_LENHI: begin
        cur_byte = head_cmd.payload_length[15:8];
        summed   = 1'b1;
        next_ph  = head_cmd.has_data ? ubxfb_pkg::PH_DATA : ubxfb_pkg::PH_CKA;
        done     = !head_cmd.has_data && !head_cmd.last;
      end
      ubxfb_pkg::PH_DATA: begin
        cur_byte = head_cmd.data_byte;
        summed   = 1'b1;
        next_ph  = ubxfb_pkg::PH_CKA;
        done     = !head_cmd.last;
      end
      ubxfb_pkg::PH_CKA: begin
        cur_byte = sum_a_r;
        next_ph  = ubxfb_pkg::PH_CKB;
      end
      ubxfb_pkg::PH_CKB: begin
        cur_byte = sum_b_r;
        done     = 1'b1;
      end
      default: begin
        cur_byte = 8'd0;
        done     = 1'b1;
      end
    endcase

    // A new frame starts its sums from zero at the first sync byte.
    sum_a_add = sum_a_r + cur_byte;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (fire && cur_ph == ubxfb_pkg::PH_SYNC1) begin
      sum_a_nxt = 8'd0;
      sum_b_nxt = 8'd0;
    end else if (fire && summed) begin
      sum_a_nxt = sum_a_add;
      sum_b_nxt = sum_b_r + sum_a_add;
    end

    started_nxt = started_r;
    phase_nxt   = phase_r;
    if (fire) begin
      started_nxt = !done;
      phase_nxt   = next_ph;
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    run_end_nxt   = run_end_r;
    frame_end_nxt = frame_end_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      run_end_nxt   = done;
      frame_end_nxt = (cur_ph == ubxfb_pkg::PH_CKB);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      phase_r     <= ubxfb_pkg::PH_SYNC1;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_a_r     <= sum_a_nxt;
    sum_b_r     <= sum_b_nxt;
    out_byte_r  <= out_byte_nxt;
    run_end_r   <= run_end_nxt;
    frame_end_r <= frame_end_nxt;
  end

  a_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_end_r) |-> run_end_r)
    else $error("frame end without run end");
  a_started_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !q_stat.empty)
    else $error("item in progress but queue empty");
  a_started_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (phase_r != ubxfb_pkg::PH_SYNC1))
    else $error("resumed item back at first sync byte");
  a_ckb_follows_cka: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cur_ph == ubxfb_pkg::PH_CKA) |=> (started_r && phase_r == ubxfb_pkg::PH_CKB))
    else $error("second checksum byte not scheduled");

endmodule
